/* rtl/gbf_pkg.sv */
package gbf_pkg;

  localparam int VW        = 7;             // vertex, time and count width
  localparam int VTX_MAX   = 64;            // highest legal vertex number
  localparam int NUM_VERT  = VTX_MAX + 1;   // vertex 0 is an ordinary vertex
  localparam int MAX_EDGES = 64;
  localparam int EW        = 6;             // edge memory address width

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_FIND = 1'b1;

  // One saved depth-first frame.
  typedef struct packed {
    logic [VW-1:0] v;
    logic [VW-1:0] pos;     // next edge index to scan
    logic [VW-1:0] low;
    logic [VW-1:0] disc;
    logic [VW-1:0] parent;
  } frame_t;

  typedef struct packed {
    logic add;
    logic find_init;
    logic root_next;
    logic root_visit;
    logic edge_read;
    logic scan_step;
    logic disc_read;
    logic push;
    logic disc_update;
    logic pop;
    logic pop_apply;
    logic emit_step;
    logic emit_none;
  } cmd_t;

  typedef struct packed {
    logic root_done;
    logic root_visited;
    logic scan_end;
    logic ev_skip;
    logic ev_visited;
    logic depth_one;
    logic no_bridges;
    logic emit_done;
  } sts_t;

endpackage

/* rtl/gbf_ctrl.sv */
module gbf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          command,
  input  gbf_pkg::sts_t sts,
  output gbf_pkg::cmd_t cmd,
  output logic          busy
);
  import gbf_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_ROOT      = 4'd1;
  localparam logic [3:0] S_SCAN_RD   = 4'd2;
  localparam logic [3:0] S_SCAN_EV   = 4'd3;
  localparam logic [3:0] S_DISC_EV   = 4'd4;
  localparam logic [3:0] S_POP       = 4'd5;
  localparam logic [3:0] S_POP_EV    = 4'd6;
  localparam logic [3:0] S_EMIT      = 4'd7;
  localparam logic [3:0] S_EMIT_NONE = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (command == CMD_FIND) begin
            cmd.find_init = 1'b1;
            state_next    = S_ROOT;
          end else begin
            cmd.add = 1'b1;
          end
        end
      end
      S_ROOT: begin
        if (sts.root_done) begin
          state_next = sts.no_bridges ? S_EMIT_NONE : S_EMIT;
        end else if (sts.root_visited) begin
          cmd.root_next = 1'b1;
        end else begin
          cmd.root_visit = 1'b1;
          state_next     = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (sts.scan_end) begin
          state_next = S_POP;
        end else begin
          cmd.edge_read = 1'b1;
          state_next    = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        if (sts.ev_skip) begin
          cmd.scan_step = 1'b1;
          state_next    = S_SCAN_RD;
        end else if (sts.ev_visited) begin
          cmd.scan_step = 1'b1;
          cmd.disc_read = 1'b1;
          state_next    = S_DISC_EV;
        end else begin
          cmd.push   = 1'b1;
          state_next = S_SCAN_RD;
        end
      end
      S_DISC_EV: begin
        cmd.disc_update = 1'b1;
        state_next      = S_SCAN_RD;
      end
      S_POP: begin
        cmd.pop    = 1'b1;
        state_next = sts.depth_one ? S_ROOT : S_POP_EV;
      end
      S_POP_EV: begin
        cmd.pop_apply = 1'b1;
        state_next    = S_SCAN_RD;
      end
      S_EMIT: begin
        cmd.emit_step = 1'b1;
        if (sts.emit_done) begin
          state_next = S_IDLE;
        end
      end
      S_EMIT_NONE: begin
        cmd.emit_none = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/gbf_datapath.sv */
module gbf_datapath (
  input  logic          clk,
  input  logic          rst,
  input  gbf_pkg::cmd_t cmd,
  output gbf_pkg::sts_t sts,
  input  logic [6:0]    from_vertex,
  input  logic [6:0]    to_vertex,
  output logic          strobe,
  output logic [6:0]    bridge_count,
  output logic [6:0]    edge_number,
  output logic          last,
  output logic          overflow
);
  import gbf_pkg::*;

  // memories
  logic [VW-1:0] edge_a_mem [MAX_EDGES];
  logic [VW-1:0] edge_b_mem [MAX_EDGES];
  logic [VW-1:0] disc_mem   [NUM_VERT];
  frame_t        stack_mem  [NUM_VERT];

  logic [VW-1:0]       edge_total;
  logic                dropped;
  logic [NUM_VERT-1:0] visited;
  logic [MAX_EDGES-1:0] mark;
  logic [VW-1:0]       count;
  logic [VW-1:0]       clk_cnt;
  logic [VW-1:0]       root_v;
  logic [VW-1:0]       depth;
  frame_t              cur;
  logic [VW-1:0]       child_low;
  logic [VW-1:0]       edge_a_q;
  logic [VW-1:0]       edge_b_q;
  logic [VW-1:0]       disc_q;
  frame_t              stack_q;
  logic [EW-1:0]       emit_e;
  logic [VW-1:0]       emit_n;

  logic          match_a;
  logic          match_b;
  logic [VW-1:0] w;
  logic          w_ok;
  logic          w_vis;
  logic          add_ok;
  logic          do_visit;
  logic [VW-1:0] vis_v;
  logic [VW-1:0] vis_parent;
  logic [VW-1:0] pos_inc;
  logic [VW-1:0] emit_n_inc;
  logic [VW-1:0] te_pos;
  logic [VW-1:0] low_min;

  assign match_a    = (edge_a_q == cur.v);
  assign match_b    = (edge_b_q == cur.v);
  assign w          = match_a ? edge_b_q : edge_a_q;
  assign w_ok       = (w <= VW'(VTX_MAX));
  assign w_vis      = w_ok ? visited[w] : 1'b0;
  assign add_ok     = (from_vertex <= VW'(VTX_MAX)) && (to_vertex <= VW'(VTX_MAX));
  assign do_visit   = cmd.root_visit | cmd.push;
  assign vis_v      = cmd.root_visit ? root_v : w;
  assign vis_parent = cmd.root_visit ? root_v : cur.v;
  assign pos_inc    = cur.pos + 1'b1;
  assign emit_n_inc = emit_n + 1'b1;
  // tree edge of the popped child sits one below the saved scan position
  assign te_pos     = stack_q.pos - 1'b1;
  assign low_min    = (child_low < stack_q.low) ? child_low : stack_q.low;

  always_comb begin
    sts.root_done    = (root_v == VW'(NUM_VERT));
    sts.root_visited = sts.root_done ? 1'b1 : visited[root_v];
    sts.scan_end     = (cur.pos >= edge_total);
    // not incident, out of range, or the edge back to the parent
    sts.ev_skip      = !(match_a || match_b) || !w_ok ||
                       ((w == cur.parent) && (cur.v != root_v));
    sts.ev_visited   = w_vis;
    sts.depth_one    = (depth == VW'(1));
    sts.no_bridges   = (count == '0);
    sts.emit_done    = mark[emit_e] && (emit_n_inc == count);
  end

  // memories: one write port, registered read
  always_ff @(posedge clk) begin
    if (cmd.add && add_ok && (edge_total < VW'(MAX_EDGES))) begin
      edge_a_mem[edge_total[EW-1:0]] <= from_vertex;
      edge_b_mem[edge_total[EW-1:0]] <= to_vertex;
    end
    if (cmd.edge_read) begin
      edge_a_q <= edge_a_mem[cur.pos[EW-1:0]];
      edge_b_q <= edge_b_mem[cur.pos[EW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (do_visit) begin
      disc_mem[vis_v] <= clk_cnt;
    end
    if (cmd.disc_read) begin
      disc_q <= disc_mem[w];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack_mem[depth - 1'b1] <= '{v: cur.v, pos: pos_inc, low: cur.low,
                                   disc: cur.disc, parent: cur.parent};
    end
    if (cmd.pop && !sts.depth_one) begin
      stack_q <= stack_mem[depth - VW'(2)];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_total <= '0;
      dropped    <= 1'b0;
      visited    <= '0;
      mark       <= '0;
      count      <= '0;
      depth      <= '0;
      strobe     <= 1'b0;
    end else begin
      strobe <= (cmd.emit_step && mark[emit_e]) || cmd.emit_none;
      if (cmd.add && add_ok) begin
        if (edge_total >= VW'(MAX_EDGES)) begin
          dropped <= 1'b1;
        end else begin
          edge_total <= edge_total + 1'b1;
        end
      end
      if (cmd.find_init) begin
        visited <= '0;
        mark    <= '0;
        count   <= '0;
      end
      if (do_visit) begin
        visited[vis_v] <= 1'b1;
      end
      if (cmd.root_visit) begin
        depth <= VW'(1);
      end else if (cmd.push) begin
        depth <= depth + 1'b1;
      end else if (cmd.pop) begin
        depth <= depth - 1'b1;
      end
      if (cmd.pop_apply && (child_low > stack_q.disc)) begin
        mark[te_pos[EW-1:0]] <= 1'b1;
        count <= count + 1'b1;
      end
    end
  end

  // walk payload
  always_ff @(posedge clk) begin
    if (cmd.find_init) begin
      clk_cnt <= '0;
      root_v  <= '0;
      emit_e  <= '0;
      emit_n  <= '0;
    end
    if (cmd.root_next) begin
      root_v <= root_v + 1'b1;
    end
    if (do_visit) begin
      cur     <= '{v: vis_v, pos: '0, low: clk_cnt, disc: clk_cnt, parent: vis_parent};
      clk_cnt <= clk_cnt + 1'b1;
    end
    if (cmd.scan_step) begin
      cur.pos <= pos_inc;
    end
    if (cmd.disc_update && (disc_q < cur.low)) begin
      cur.low <= disc_q;
    end
    if (cmd.pop) begin
      child_low <= cur.low;
    end
    if (cmd.pop_apply) begin
      cur <= '{v: stack_q.v, pos: stack_q.pos, low: low_min,
               disc: stack_q.disc, parent: stack_q.parent};
    end
    if (cmd.emit_step) begin
      emit_e <= emit_e + 1'b1;
      if (mark[emit_e]) begin
        emit_n <= emit_n_inc;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit_step) begin
      bridge_count <= count;
      edge_number  <= VW'(emit_e) + 1'b1;
      last         <= (emit_n_inc == count);
      overflow     <= dropped;
    end else if (cmd.emit_none) begin
      bridge_count <= '0;
      edge_number  <= '0;
      last         <= 1'b1;
      overflow     <= dropped;
    end
  end

endmodule

/* rtl/graph_bridge_finder.sv */
// Channel  Ports                                      Transaction
// -------  -----------------------------------------  ---------------------------------
// input    start, busy, command, from_vertex,          accepted when start & !busy
//          to_vertex
// result   strobe, bridge_count, edge_number, last,    one per strobe cycle, no stall
//          overflow
//
// An add transaction leaves busy low, so adds may come every cycle.
// A find walks the stored edge list, each vertex scanning the whole list: each edge
// scanned is read then evaluated, a back-edge adds a discovery-time lookup, each
// root vertex is tried in turn, and a vertex retires by end of scan, pop and parent
// reload (no reload for a root), then one mark bit per cycle up to the last bridge
// (a single no-bridge result when there are none). Results are registered from each
// emit step, the last in the same cycle that busy drops. Run time is set by the scan.
// Reset is synchronous: edges, overflow flag and marks clear. The receiver cannot
// stall; each result is on the ports for exactly one cycle.
module graph_bridge_finder (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       command,
  input  logic [6:0] from_vertex,
  input  logic [6:0] to_vertex,
  output logic       busy,
  output logic       strobe,
  output logic [6:0] bridge_count,
  output logic [6:0] edge_number,
  output logic       last,
  output logic       overflow
);
  import gbf_pkg::*;

  cmd_t cmd;   // controller -> datapath
  sts_t sts;   // datapath -> controller

  // sequencer: walk steps, pops, emission
  gbf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  // edge store, walk stack, discovery times, bridge marks, result register
  gbf_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .from_vertex  (from_vertex),
    .to_vertex    (to_vertex),
    .strobe       (strobe),
    .bridge_count (bridge_count),
    .edge_number  (edge_number),
    .last         (last),
    .overflow     (overflow)
  );

endmodule

/* rtl/gbf_checker.sv */
module gbf_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       command,
  input logic       busy,
  input logic       strobe,
  input logic [6:0] bridge_count,
  input logic [6:0] edge_number,
  input logic       last
);
  import gbf_pkg::*;

  // final result of a run closes it
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe)
    else $error("result after last");

  // an add never makes the block busy
  a_add_idle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && command == CMD_ADD |=> !busy)
    else $error("add left block busy");

  // empty run has exactly the no-bridge result
  a_none: assert property (@(posedge clk) disable iff (rst)
    strobe && bridge_count == 7'd0 |-> edge_number == 7'd0 && last)
    else $error("bad no-bridge result");

  // bridge numbers ascend within a run
  a_ascend: assert property (@(posedge clk) disable iff (rst)
    strobe && $past(strobe) && !$past(last) |-> edge_number > $past(edge_number))
    else $error("edge numbers not ascending");

endmodule

bind graph_bridge_finder gbf_checker u_gbf_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .command      (command),
  .busy         (busy),
  .strobe       (strobe),
  .bridge_count (bridge_count),
  .edge_number  (edge_number),
  .last         (last)
);
